FILE: sv/eye_candidate_selector_top_defines.svh
// ----------------------------------------------------------------------------
// Eye candidate selector assertion macros
// Shared concurrent check wrappers, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef EYE_CANDIDATE_SELECTOR_TOP_DEFINES_SVH
`define EYE_CANDIDATE_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication check
`define ECS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define ECS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ecs_pkg.sv
// ----------------------------------------------------------------------------
// Eye candidate selector package
// Configuration register indexes and port constants.
// ----------------------------------------------------------------------------
package ecs_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FACE_LEFT   = 3'd0,
    CFG_FACE_TOP    = 3'd1,
    CFG_FACE_WIDTH  = 3'd2,
    CFG_FACE_HEIGHT = 3'd3,
    CFG_RADIUS_MIN  = 3'd4,
    CFG_RADIUS_MAX  = 3'd5
  } cfg_idx_e;

endpackage

FILE: sv/eye_candidate_selector_top.sv
// ----------------------------------------------------------------------------
// Eye candidate selector
// Keeps the smallest plausible left and right eye box per frame and reports
// both centres on the frame's last candidate.
// ----------------------------------------------------------------------------
// Path: a tlast request passes the input register, which holds centre, area
//   and keep, then the result register, loaded by the judgement against the
//   per-side best; a stalled result can hold it between the two.
// Throughput: one candidate per cycle; only a stalled result holds the input.
// Reset: asynchronous, active low; clears pipeline valids, per-side best
//   state and configuration (radius_max comes up all ones, the rest zero).
module eye_candidate_selector_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [ecs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  // candidate stream
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // box_x, box_y, box_w, box_h (low to high), zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // side: 0 left eye, 1 right eye
  input  logic                    s_axis_tuser_i,
  input  logic                    s_axis_tlast_i,
  // result stream
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // left_cx, left_cy, right_cx, right_cy, left_valid, right_valid, eye_count
  // (low to high), zero padded to bytes
  output logic [((4*COORD_BITS+15)/8)*8-1:0] m_axis_tdata_o
);

  import ecs_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned OW   = COORD_BITS + 1;
  localparam int unsigned AW   = 2 * COORD_BITS;
  localparam int unsigned ODW  = ((4*COORD_BITS+15)/8)*8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CB-1:0] face_left_q, face_top_q, face_width_q, face_height_q;
  logic [CB-1:0] radius_min_q, radius_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_left_q   <= '0;
      face_top_q    <= '0;
      face_width_q  <= '0;
      face_height_q <= '0;
      radius_min_q  <= '0;
      radius_max_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FACE_LEFT:   face_left_q   <= cfg_data_i;
        CFG_FACE_TOP:    face_top_q    <= cfg_data_i;
        CFG_FACE_WIDTH:  face_width_q  <= cfg_data_i;
        CFG_FACE_HEIGHT: face_height_q <= cfg_data_i;
        CFG_RADIUS_MIN:  radius_min_q  <= cfg_data_i;
        CFG_RADIUS_MAX:  radius_max_q  <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side: box geometry and the window tests, ahead of the input register
  // --------------------------------------------------------------------------
  logic [CB-1:0] in_bx, in_by, in_bw, in_bh;
  logic [OW-1:0] in_cx, in_cy, rad_sum, mid_y, half_x, face_right;
  logic [CB-1:0] radius;
  logic [AW-1:0] in_area;
  logic          in_band, in_radius, in_half, in_keep;

  assign in_bx = s_axis_tdata_i[0*CB +: CB];
  assign in_by = s_axis_tdata_i[1*CB +: CB];
  assign in_bw = s_axis_tdata_i[2*CB +: CB];
  assign in_bh = s_axis_tdata_i[3*CB +: CB];

  always_comb begin
    in_cx      = {1'b0, in_bx} + {2'b00, in_bw[CB-1:1]};
    in_cy      = {1'b0, in_by} + {2'b00, in_bh[CB-1:1]};
    rad_sum    = {1'b0, in_bw} + {1'b0, in_bh};
    radius     = rad_sum[OW-1:1];
    mid_y      = {1'b0, face_top_q} + {2'b00, face_height_q[CB-1:1]};
    half_x     = {1'b0, face_left_q} + {2'b00, face_width_q[CB-1:1]};
    face_right = {1'b0, face_left_q} + {1'b0, face_width_q};
    in_area    = {{CB{1'b0}}, in_bw} * {{CB{1'b0}}, in_bh};
    // upper band of the face: half the mid line down to the mid line
    in_band    = (in_cy <= mid_y) && (in_cy >= {1'b0, mid_y[OW-1:1]});
    in_radius  = (radius >= radius_min_q) && (radius <= radius_max_q);
    if (s_axis_tuser_i) begin
      in_half = (in_cx < face_right) && (in_cx > half_x);
    end else begin
      in_half = (in_cx < half_x) && (in_cx > {1'b0, face_left_q});
    end
    in_keep    = in_band && in_radius && in_half;
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic          s1_valid_q, s1_valid_d;
  logic          s1_side_q, s1_last_q, s1_keep_q;
  logic [OW-1:0] s1_cx_q, s1_cy_q;
  logic [AW-1:0] s1_area_q;

  logic out_valid_q, out_valid_d;
  logic out_free, s1_proc, s_accept, s1_emit;

  // a request without tlast never waits on the result side
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_proc         = s1_valid_q && (!s1_last_q || out_free);
  assign s1_emit         = s1_proc && s1_last_q;
  assign s_axis_tready_o = !s1_valid_q || s1_proc;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_side_q <= s_axis_tuser_i;
      s1_last_q <= s_axis_tlast_i;
      s1_keep_q <= in_keep;
      s1_cx_q   <= in_cx;
      s1_cy_q   <= in_cy;
      s1_area_q <= in_area;
    end
  end

  // --------------------------------------------------------------------------
  // Per-side best box; earlier box wins on equal area
  // --------------------------------------------------------------------------
  logic [AW-1:0] left_area_q, left_area_d, right_area_q, right_area_d;
  logic [OW-1:0] left_cx_q, left_cx_d, left_cy_q, left_cy_d;
  logic [OW-1:0] right_cx_q, right_cx_d, right_cy_q, right_cy_d;
  logic          left_seen_q, left_seen_d, right_seen_q, right_seen_d;
  logic          left_take, right_take;

  assign left_take  = s1_proc && s1_keep_q && !s1_side_q &&
                      (!left_seen_q || (s1_area_q < left_area_q));
  assign right_take = s1_proc && s1_keep_q && s1_side_q &&
                      (!right_seen_q || (s1_area_q < right_area_q));

  always_comb begin
    left_area_d  = left_area_q;
    left_cx_d    = left_cx_q;
    left_cy_d    = left_cy_q;
    left_seen_d  = left_seen_q;
    right_area_d = right_area_q;
    right_cx_d   = right_cx_q;
    right_cy_d   = right_cy_q;
    right_seen_d = right_seen_q;
    if (left_take) begin
      left_area_d = s1_area_q;
      left_cx_d   = s1_cx_q;
      left_cy_d   = s1_cy_q;
      left_seen_d = 1'b1;
    end
    if (right_take) begin
      right_area_d = s1_area_q;
      right_cx_d   = s1_cx_q;
      right_cy_d   = s1_cy_q;
      right_seen_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [OW-1:0] res_lcx_q, res_lcy_q, res_rcx_q, res_rcy_q;
  logic          res_lval_q, res_rval_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      left_area_q  <= '1;
      left_cx_q    <= '0;
      left_cy_q    <= '0;
      left_seen_q  <= 1'b0;
      right_area_q <= '1;
      right_cx_q   <= '0;
      right_cy_q   <= '0;
      right_seen_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_emit) begin
        // frame closed: back to the empty state
        left_area_q  <= '1;
        left_cx_q    <= '0;
        left_cy_q    <= '0;
        left_seen_q  <= 1'b0;
        right_area_q <= '1;
        right_cx_q   <= '0;
        right_cy_q   <= '0;
        right_seen_q <= 1'b0;
      end else begin
        left_area_q  <= left_area_d;
        left_cx_q    <= left_cx_d;
        left_cy_q    <= left_cy_d;
        left_seen_q  <= left_seen_d;
        right_area_q <= right_area_d;
        right_cx_q   <= right_cx_d;
        right_cy_q   <= right_cy_d;
        right_seen_q <= right_seen_d;
      end
    end
  end

  // centres of an empty side are already zero from the cleared state
  always_ff @(posedge clk_i) begin
    if (s1_emit) begin
      res_lcx_q  <= left_cx_d;
      res_lcy_q  <= left_cy_d;
      res_rcx_q  <= right_cx_d;
      res_rcy_q  <= right_cy_d;
      res_lval_q <= left_seen_d;
      res_rval_q <= right_seen_d;
    end
  end

  logic [1:0] res_count;
  assign res_count = {1'b0, res_lval_q} + {1'b0, res_rval_q};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ODW'({res_count, res_rval_q, res_lval_q,
                                 res_rcy_q, res_rcx_q, res_lcy_q, res_lcx_q});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "eye_candidate_selector_top_defines.svh"

  `ECS_ASSERT_NXT(a_clear_after_last, s1_emit, !left_seen_q && !right_seen_q, "state not cleared after last")
  `ECS_ASSERT_NXT(a_left_area_mono, left_seen_q && !s1_emit, left_area_q <= $past(left_area_q), "left best area grew")
  `ECS_ASSERT_IMP(a_left_zero_centre, out_valid_q && !res_lval_q, res_lcx_q == '0 && res_lcy_q == '0, "empty left side has centre")
  `ECS_ASSERT_IMP(a_no_emit_on_stall, s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready_i, !s1_proc, "result overwritten while stalled")

endmodule
